// ===== design/salru_pkg.sv =====
// shared codes and types for the set-associative lru cache tracker
`default_nettype none
package salru_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] outcome_t;
  typedef logic [1:0] cfg_index_t;

  localparam op_t OP_LOAD   = 2'd0;
  localparam op_t OP_STORE  = 2'd1;
  localparam op_t OP_MODIFY = 2'd2;
  localparam op_t OP_IFETCH = 2'd3;

  localparam outcome_t OUTCOME_HIT   = 2'd0;
  localparam outcome_t OUTCOME_FILL  = 2'd1;
  localparam outcome_t OUTCOME_EVICT = 2'd2;

  localparam cfg_index_t CFG_SET_BITS    = 2'd0;
  localparam cfg_index_t CFG_BLOCK_BITS  = 2'd1;
  localparam cfg_index_t CFG_WAYS_IN_USE = 2'd2;

  localparam int CFG_DATA_W = 6;
  localparam int COUNT_W    = 32;

endpackage
`default_nettype wire

// ===== design/salru_row_ram.sv =====
// one-write one-read set row memory with registered read data
`default_nettype none
module salru_row_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== design/set_assoc_lru_cache_tracker_unit.sv =====
// top level: tag-only set-associative cache tracker with lru replacement
//
//  channel | dir | handshake               | word
//  --------+-----+-------------------------+---------------------------------------
//  in      | in  | in_tvalid / in_tready   | in_tdata: operation, address
//  out     | out | out_tvalid / out_tready | out_tdata: outcome, hit/miss/evict totals
//  cfg     | in  | cfg_wr_en               | cfg_index, cfg_wdata
//
//  an access, ways being ways_in_use held to 1..MAX_WAYS, runs two set/tag decode
//  steps through the shared shifter, the ways one at a time through the shared
//  tag/stamp compare, one row write-back and one output load; a load or store
//  adds its accept step, modify makes two accesses, a fetch is only accepted
//  in_tready is high only while the sequencer is idle; a full output register
//  holds the sequencer in its output step until out_tready
//  synchronous active-low reset; per-set row flags make unwritten rows read as
//  empty, so no clearing pass follows reset
`default_nettype none
module set_assoc_lru_cache_tracker_unit #(
  parameter int MAX_SET_BITS  = 6,
  parameter int MAX_WAYS      = 8,
  parameter int ADDRESS_WIDTH = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [71:0]  in_tdata,    // [1:0] operation, [65:2] address
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [103:0]      out_tdata,   // [1:0] outcome, [33:2] hit_total,
                                         // [65:34] miss_total, [97:66] eviction_total
  output logic              out_tlast,   // last_of_item
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [5:0]   cfg_wdata
);

  localparam int SETS    = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CW      = salru_pkg::COUNT_W;
  localparam int LINE_W  = 1 + ADDRESS_WIDTH + CW;
  localparam int ROW_W   = MAX_WAYS * LINE_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SET    = 3'd1;
  localparam logic [2:0] S_TAG    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;

  logic [2:0] set_bits_r;
  logic [5:0] block_bits_r;
  logic [3:0] ways_r;

  logic [ADDRESS_WIDTH-1:0] addr_r;
  logic                     second_r;
  logic [SET_W-1:0]         set_r;
  logic [ADDRESS_WIDTH-1:0] tag_r;
  logic                     row_ok_r;
  logic [SETS-1:0]          row_init_r;

  logic [WAY_W-1:0] way_r;
  logic             hit_found_r, free_found_r;
  logic [WAY_W-1:0] hit_way_r, free_way_r, min_way_r;
  logic [CW-1:0]    min_stamp_r;

  logic [CW-1:0] clock_r, hit_cnt_r, miss_cnt_r, evict_cnt_r;
  salru_pkg::outcome_t res_outcome_r;

  logic           out_valid_r;
  logic [103:0]   out_data_r;
  logic           out_last_r;

  // configuration decode
  logic [3:0] sb;
  logic [4:0] wcfg, weff;
  logic [WAY_W-1:0] ways_last;
  logic [SET_W-1:0] set_mask;

  always_comb begin
    sb = ({1'b0, set_bits_r} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : {1'b0, set_bits_r};
    wcfg = {1'b0, ways_r};
    if (wcfg == 5'd0) begin
      weff = 5'd1;
    end else if (wcfg > 5'(MAX_WAYS)) begin
      weff = 5'(MAX_WAYS);
    end else begin
      weff = wcfg;
    end
    ways_last = WAY_W'(weff - 5'd1);
    set_mask = ~({SET_W{1'b1}} << sb);
  end

  // shared shifter: block offset for the set, then block plus set bits for the tag
  logic [6:0]               sh_amt;
  logic [ADDRESS_WIDTH-1:0] sh_out;
  logic [SET_W-1:0]         set_calc;

  always_comb begin
    if (state_r == S_SET) begin
      sh_amt = {1'b0, block_bits_r};
    end else begin
      sh_amt = 7'({1'b0, block_bits_r} + {3'd0, sb});
    end
    sh_out   = addr_r >> sh_amt;
    set_calc = sh_out[SET_W-1:0] & set_mask;
  end

  // row memory
  logic [ROW_W-1:0] rd_row_r;
  logic [ROW_W-1:0] row_src;
  logic [ROW_W-1:0] row_new;
  logic             mem_wr;

  salru_row_ram #(
    .DEPTH  (SETS),
    .ADDR_W (SET_W),
    .DATA_W (ROW_W)
  ) u_row_ram (
    .clk       (clk),
    .wr_en     (mem_wr),
    .wr_addr   (set_r),
    .wr_data   (row_new),
    .rd_en     (state_r == S_SET),
    .rd_addr   (set_calc),
    .rd_data_r (rd_row_r)
  );

  assign row_src = row_ok_r ? rd_row_r : '0;
  assign mem_wr  = (state_r == S_UPDATE);

  // shared compare on the line under the way counter
  logic [LINE_W-1:0]        cur_line;
  logic                     cur_valid;
  logic [ADDRESS_WIDTH-1:0] cur_tag;
  logic [CW-1:0]            cur_stamp;

  always_comb begin
    cur_line  = row_src[way_r*LINE_W +: LINE_W];
    cur_valid = cur_line[0];
    cur_tag   = cur_line[ADDRESS_WIDTH:1];
    cur_stamp = cur_line[LINE_W-1 -: CW];
  end

  // target way and rewritten row
  logic [WAY_W-1:0]    tgt_way;
  salru_pkg::outcome_t outcome_calc;

  always_comb begin
    if (hit_found_r) begin
      tgt_way      = hit_way_r;
      outcome_calc = salru_pkg::OUTCOME_HIT;
    end else if (free_found_r) begin
      tgt_way      = free_way_r;
      outcome_calc = salru_pkg::OUTCOME_FILL;
    end else begin
      tgt_way      = min_way_r;
      outcome_calc = salru_pkg::OUTCOME_EVICT;
    end
    row_new = row_src;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (tgt_way == WAY_W'(w)) begin
        row_new[w*LINE_W +: LINE_W] = {clock_r, tag_r, 1'b1};
      end
    end
  end

  logic in_acc, out_free;
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tdata[1:0] != salru_pkg::OP_IFETCH)) begin
          state_nxt = S_SET;
        end
      end
      S_SET:  state_nxt = S_TAG;
      S_TAG:  state_nxt = S_SCAN;
      S_SCAN: begin
        if (way_r == ways_last) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = second_r ? S_SET : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      set_bits_r   <= 3'd0;
      block_bits_r <= 6'd0;
      ways_r       <= 4'd1;
      row_init_r   <= '0;
      clock_r      <= '0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          salru_pkg::CFG_SET_BITS:    set_bits_r   <= cfg_wdata[2:0];
          salru_pkg::CFG_BLOCK_BITS:  block_bits_r <= cfg_wdata;
          salru_pkg::CFG_WAYS_IN_USE: ways_r       <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (state_r == S_SET) begin
        clock_r <= clock_r + 1'b1;
      end
      if (state_r == S_UPDATE) begin
        row_init_r[set_r] <= 1'b1;
        if (hit_found_r) begin
          hit_cnt_r <= hit_cnt_r + 1'b1;
        end else begin
          miss_cnt_r <= miss_cnt_r + 1'b1;
          if (!free_found_r) begin
            evict_cnt_r <= evict_cnt_r + 1'b1;
          end
        end
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r   <= in_tdata[2 +: ADDRESS_WIDTH];
      second_r <= (in_tdata[1:0] == salru_pkg::OP_MODIFY);
    end
    if (state_r == S_SET) begin
      set_r <= set_calc;
    end
    if (state_r == S_TAG) begin
      tag_r        <= sh_out;
      row_ok_r     <= row_init_r[set_r];
      way_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end
    if (state_r == S_SCAN) begin
      if (cur_valid && (cur_tag == tag_r) && !hit_found_r) begin
        hit_found_r <= 1'b1;
        hit_way_r   <= way_r;
      end
      if (!cur_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_way_r   <= way_r;
      end
      // strict compare keeps the lowest way on equal stamps
      if ((way_r == '0) || (cur_stamp < min_stamp_r)) begin
        min_stamp_r <= cur_stamp;
        min_way_r   <= way_r;
      end
      if (way_r != ways_last) begin
        way_r <= way_r + 1'b1;
      end
    end
    if (state_r == S_UPDATE) begin
      res_outcome_r <= outcome_calc;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {6'd0, evict_cnt_r, miss_cnt_r, hit_cnt_r, res_outcome_r};
      out_last_r <= !second_r;
      second_r   <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire
